FILE: hw/rtl/smr_pkg.sv
package smr_pkg;

  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;
  localparam logic [7:0] CheckSeed  = 8'hFF;
  localparam logic [7:0] CmdLimit   = 8'd5;

  localparam logic [2:0] CmdOverCurrent = 3'd2;
  localparam logic [2:0] CmdIndA        = 3'd1;
  localparam logic [2:0] CmdIndB        = 3'd3;
  localparam logic [2:0] CmdIndC        = 3'd4;
  localparam logic [7:0] IndLength      = 8'd3;

  typedef enum logic [1:0] {
    StatusGood      = 2'd0,
    StatusBadCheck  = 2'd1,
    StatusBadEscape = 2'd2
  } frame_status_e;

endpackage

FILE: hw/rtl/slip_message_receiver.sv
// slip_message_receiver
// Takes raw serial bytes on the in channel (in_valid_i, in_ready_o, rx_byte_i), one word per
// accepted handshake, removes SLIP escaping and parses command / length / payload / checksum
// frames. One result word leaves on the out channel (out_valid_o, out_ready_i and the field
// ports) for each completed frame and for each bad escape sequence; other bytes give none.
// An accepted byte is held in an input register, then decoded by a single pass of logic
// that updates the parser state and loads the result register.
// Throughput is one byte per cycle; the only limit is the single result register: while a
// result waits and out_ready_i is low, one more byte is still taken into the input register,
// and a byte that would produce a second result holds there (in_ready_o drops) until the
// waiting result is taken. Bytes that produce no result pass through the decoder meanwhile.
// Reset (rst_ni low, asynchronous) empties both registers and returns the parser to idle
// with no escape pending and the running checksum seeded; no clearing pass is needed.
module slip_message_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [2:0]  command_code_o,
  output logic [7:0]  payload_length_o,
  output logic [15:0] ind_value_o,
  output logic [7:0]  ind_channel_o,
  output logic        indication_valid_o,
  output logic        overcurrent_alarm_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhCmd   = 3'd1;
  localparam logic [2:0] PhLen   = 3'd2;
  localparam logic [2:0] PhData  = 3'd3;
  localparam logic [2:0] PhCheck = 3'd4;

  logic       byte_valid_q;
  logic [7:0] byte_q;

  logic       esc_q, esc_d;
  logic [2:0] phase_q, phase_d;
  logic [2:0] cmd_q, cmd_d;
  logic [7:0] len_q, len_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] chk_q, chk_d;
  logic [7:0] head_q [3];
  logic       head_we;

  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic [2:0] ocmd_q, ocmd_d;
  logic [7:0] olen_q, olen_d;
  logic [15:0] oval_q, oval_d;
  logic [7:0] ochan_q, ochan_d;
  logic       oind_q, oind_d;
  logic       oalarm_q, oalarm_d;

  logic       feed_en;
  logic [7:0] fb;
  logic       res_gen;
  logic       advance;
  logic       good;
  logic [7:0] cnt_inc;
  logic [7:0] p0, p1, p2;

  assign cnt_inc = cnt_q + 8'd1;
  assign advance = byte_valid_q && (!res_gen || !out_valid_q || out_ready_i);
  assign in_ready_o = !byte_valid_q || advance;

  // escape removal
  always_comb begin
    esc_d   = esc_q;
    feed_en = 1'b0;
    fb      = byte_q;
    if (esc_q) begin
      esc_d = 1'b0;
      if (byte_q == smr_pkg::SlipEscEnd) begin
        feed_en = 1'b1;
        fb      = smr_pkg::SlipEnd;
      end else if (byte_q == smr_pkg::SlipEscEsc) begin
        feed_en = 1'b1;
        fb      = smr_pkg::SlipEsc;
      end
    end else if (byte_q == smr_pkg::SlipEsc) begin
      esc_d = 1'b1;
    end else if (byte_q != smr_pkg::SlipEnd) begin
      feed_en = 1'b1;
    end
  end

  assign good = (fb == chk_q);
  assign p0 = (len_q > 8'd0) ? head_q[0] : 8'd0;
  assign p1 = (len_q > 8'd1) ? head_q[1] : 8'd0;
  assign p2 = (len_q > 8'd2) ? head_q[2] : 8'd0;

  // frame parser
  always_comb begin
    phase_d  = phase_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    chk_d    = chk_q;
    head_we  = 1'b0;
    res_gen  = 1'b0;
    status_d = smr_pkg::StatusGood;
    ocmd_d   = '0;
    olen_d   = '0;
    oval_d   = '0;
    ochan_d  = '0;
    oind_d   = 1'b0;
    oalarm_d = 1'b0;
    if (esc_q && !feed_en) begin
      res_gen  = 1'b1;
      status_d = smr_pkg::StatusBadEscape;
    end else if (!esc_q && byte_q == smr_pkg::SlipEnd) begin
      phase_d = PhCmd;
    end else if (feed_en) begin
      case (phase_q)
        PhCmd: begin
          if (fb < smr_pkg::CmdLimit) begin
            cmd_d   = fb[2:0];
            chk_d   = smr_pkg::CheckSeed ^ fb;
            phase_d = PhLen;
          end else begin
            phase_d = PhIdle;
          end
        end
        PhLen: begin
          len_d   = fb;
          cnt_d   = 8'd0;
          chk_d   = chk_q ^ fb;
          phase_d = (fb != 8'd0) ? PhData : PhCheck;
        end
        PhData: begin
          head_we = (cnt_q < 8'd3);
          cnt_d   = cnt_inc;
          chk_d   = chk_q ^ fb;
          if (cnt_inc == len_q) begin
            phase_d = PhCheck;
          end
        end
        PhCheck: begin
          res_gen  = 1'b1;
          status_d = good ? smr_pkg::StatusGood : smr_pkg::StatusBadCheck;
          ocmd_d   = cmd_q;
          olen_d   = len_q;
          oval_d   = {p1, p0};
          ochan_d  = p2;
          oind_d   = good && len_q == smr_pkg::IndLength &&
                     (cmd_q inside {smr_pkg::CmdIndA, smr_pkg::CmdIndB, smr_pkg::CmdIndC});
          oalarm_d = good && cmd_q == smr_pkg::CmdOverCurrent;
          phase_d  = PhIdle;
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      esc_q        <= 1'b0;
      phase_q      <= PhIdle;
      cmd_q        <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      chk_q        <= smr_pkg::CheckSeed;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        byte_valid_q <= in_valid_i;
      end
      if (advance) begin
        esc_q   <= esc_d;
        phase_q <= phase_d;
        cmd_q   <= cmd_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        chk_q   <= chk_d;
      end
      if (advance && res_gen) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
    if (advance && head_we) begin
      head_q[cnt_q[1:0]] <= fb;
    end
    if (advance && res_gen) begin
      status_q <= status_d;
      ocmd_q   <= ocmd_d;
      olen_q   <= olen_d;
      oval_q   <= oval_d;
      ochan_q  <= ochan_d;
      oind_q   <= oind_d;
      oalarm_q <= oalarm_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign frame_status_o      = status_q;
  assign command_code_o      = ocmd_q;
  assign payload_length_o    = olen_q;
  assign ind_value_o         = oval_q;
  assign ind_channel_o       = ochan_q;
  assign indication_valid_o  = oind_q;
  assign overcurrent_alarm_o = oalarm_q;

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_gen |=> out_valid_q)
    else $error("result word not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(advance && res_gen))
    else $error("waiting result overwritten");

  a_ind_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oind_q |-> status_q == smr_pkg::StatusGood && olen_q == smr_pkg::IndLength)
    else $error("indication on a bad or wrong-length frame");

  a_alarm_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oalarm_q |-> status_q == smr_pkg::StatusGood &&
      ocmd_q == smr_pkg::CmdOverCurrent)
    else $error("alarm on a bad frame");

endmodule

FILE: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 600;

  typedef enum logic [2:0] {
    PhIdle, PhCmd, PhLen, PhData, PhCheck
  } parse_ph_e;

  typedef enum int {
    RxFree, RxRandom, RxPattern
  } rx_mode_e;

  typedef struct packed {
    smr_pkg::frame_status_e status;
    logic [2:0]    cmd;
    logic [7:0]    len;
    logic [15:0]   value;
    logic [7:0]    chan;
    logic          ind;
    logic          oc;
  } report_t;

  typedef struct packed {
    logic [7:0] b;
    logic       fixed;
    report_t    rep;
  } word_t;

  localparam report_t NoRep     = '0;
  localparam report_t BadEscRep = '{smr_pkg::StatusBadEscape, 3'd0, 8'd0, 16'd0, 8'd0,
                                    1'b0, 1'b0};
  localparam report_t AlarmRep  = '{smr_pkg::StatusGood, smr_pkg::CmdOverCurrent, 8'd0,
                                    16'd0, 8'd0, 1'b0, 1'b1};

  localparam word_t DirTbl [27] = '{
    '{8'hDB, 1'b0, NoRep}, '{8'h00, 1'b1, BadEscRep},
    '{8'hFF, 1'b0, NoRep},
    '{8'hC0, 1'b0, NoRep}, '{8'h02, 1'b0, NoRep}, '{8'h00, 1'b0, NoRep},
    '{8'hFD, 1'b1, AlarmRep},
    '{8'hC0, 1'b0, NoRep}, '{8'h01, 1'b0, NoRep}, '{8'h03, 1'b0, NoRep},
    '{8'h34, 1'b0, NoRep}, '{8'h12, 1'b0, NoRep}, '{8'h07, 1'b0, NoRep},
    '{8'hDC, 1'b0, NoRep},
    '{8'hC0, 1'b0, NoRep}, '{8'hC0, 1'b0, NoRep}, '{8'h05, 1'b0, NoRep},
    '{8'hC0, 1'b0, NoRep}, '{8'h04, 1'b0, NoRep}, '{8'h02, 1'b0, NoRep},
    '{8'hDB, 1'b0, NoRep}, '{8'hDC, 1'b0, NoRep}, '{8'hDB, 1'b0, NoRep},
    '{8'hDD, 1'b0, NoRep}, '{8'h00, 1'b0, NoRep},
    '{8'hDB, 1'b0, NoRep}, '{8'hC0, 1'b1, BadEscRep}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_status;
  logic [2:0]  command_code;
  logic [7:0]  payload_length;
  logic [15:0] ind_value;
  logic [7:0]  ind_channel;
  logic        indication_valid;
  logic        overcurrent_alarm;

  int errors = 0;

  word_t   stim_q [$];
  report_t frame_reports_q [$];

  logic       esc_pend;
  parse_ph_e  parse_ph;
  logic [2:0] frame_cmd;
  logic [7:0] frame_len;
  logic [7:0] rx_count;
  logic [7:0] run_check;
  logic [7:0] head [3];

  slip_message_receiver dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .frame_status_o      (frame_status),
    .command_code_o      (command_code),
    .payload_length_o    (payload_length),
    .ind_value_o         (ind_value),
    .ind_channel_o       (ind_channel),
    .indication_valid_o  (indication_valid),
    .overcurrent_alarm_o (overcurrent_alarm)
  );

  always #1 clk = ~clk;

  function automatic logic parse_frame_byte(input logic [7:0] b, output report_t rep);
    logic good;
    rep = '0;
    parse_frame_byte = 1'b0;
    case (parse_ph)
      PhCmd: begin
        if (b < smr_pkg::CmdLimit) begin
          frame_cmd = b[2:0];
          run_check = smr_pkg::CheckSeed ^ b;
          parse_ph = PhLen;
        end else begin
          parse_ph = PhIdle;
        end
      end
      PhLen: begin
        frame_len = b;
        rx_count = 8'd0;
        run_check = run_check ^ b;
        parse_ph = (b != 8'd0) ? PhData : PhCheck;
      end
      PhData: begin
        if (rx_count < 8'd3) head[rx_count[1:0]] = b;
        rx_count = rx_count + 8'd1;
        run_check = run_check ^ b;
        if (rx_count == frame_len) parse_ph = PhCheck;
      end
      PhCheck: begin
        good = (b == run_check);
        rep.status = good ? smr_pkg::StatusGood : smr_pkg::StatusBadCheck;
        rep.cmd = frame_cmd;
        rep.len = frame_len;
        rep.value = {(frame_len > 8'd1) ? head[1] : 8'h00,
                     (frame_len > 8'd0) ? head[0] : 8'h00};
        rep.chan = (frame_len > 8'd2) ? head[2] : 8'h00;
        rep.ind = good && frame_len == smr_pkg::IndLength &&
                  (frame_cmd == smr_pkg::CmdIndA || frame_cmd == smr_pkg::CmdIndB ||
                   frame_cmd == smr_pkg::CmdIndC);
        rep.oc = good && frame_cmd == smr_pkg::CmdOverCurrent;
        parse_ph = PhIdle;
        parse_frame_byte = 1'b1;
      end
      default: parse_ph = PhIdle;
    endcase
  endfunction

  function automatic logic decode_slip_byte(input logic [7:0] raw, output report_t rep);
    rep = '0;
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (raw == smr_pkg::SlipEscEnd) return parse_frame_byte(smr_pkg::SlipEnd, rep);
      if (raw == smr_pkg::SlipEscEsc) return parse_frame_byte(smr_pkg::SlipEsc, rep);
      rep.status = smr_pkg::StatusBadEscape;
      return 1'b1;
    end
    if (raw == smr_pkg::SlipEsc) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (raw == smr_pkg::SlipEnd) begin
      parse_ph = PhCmd;
      return 1'b0;
    end
    return parse_frame_byte(raw, rep);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0: return smr_pkg::SlipEnd;
      1: return smr_pkg::SlipEsc;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_raw(input logic [7:0] b);
    stim_q.push_back('{b, 1'b0, NoRep});
  endtask

  task automatic push_data(input logic [7:0] d);
    if (d == smr_pkg::SlipEnd) begin
      push_raw(smr_pkg::SlipEsc);
      push_raw(smr_pkg::SlipEscEnd);
    end else if (d == smr_pkg::SlipEsc) begin
      push_raw(smr_pkg::SlipEsc);
      push_raw(smr_pkg::SlipEscEsc);
    end else begin
      push_raw(d);
    end
  endtask

  task automatic push_frame(input logic broken);
    logic [7:0]  body [$];
    logic [7:0]  sum;
    logic [7:0]  bad;
    int unsigned len;
    int          cut_at = -1;
    int          bad_at = -1;
    body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(5, 255))
                                                : 8'($urandom_range(0, 4)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: len = 3;
      9: len = ($urandom_range(0, 2) == 0) ? $urandom_range(200, 255) : $urandom_range(7, 20);
      default: len = $urandom_range(0, 6);
    endcase
    body.push_back(8'(len));
    repeat (len) body.push_back(pick_byte());
    sum = smr_pkg::CheckSeed;
    foreach (body[i]) sum = sum ^ body[i];
    if ($urandom_range(0, 6) == 0) sum = sum ^ 8'($urandom_range(1, 255));
    body.push_back(sum);
    if (broken) begin
      if ($urandom_range(0, 1) == 0) cut_at = $urandom_range(1, body.size() - 1);
      else bad_at = $urandom_range(0, body.size() - 1);
    end
    push_raw(smr_pkg::SlipEnd);
    foreach (body[i]) begin
      if (i == cut_at) break;
      if (i == bad_at) begin
        do bad = 8'($urandom);
        while (bad == smr_pkg::SlipEscEnd || bad == smr_pkg::SlipEscEsc);
        push_raw(smr_pkg::SlipEsc);
        push_raw(bad);
      end
      push_data(body[i]);
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    int      burst;
    word_t   w;
    report_t rep;
    esc_pend = 1'b0;
    parse_ph = PhIdle;
    frame_cmd = 3'd0;
    frame_len = 8'd0;
    rx_count = 8'd0;
    run_check = smr_pkg::CheckSeed;
    foreach (DirTbl[i]) stim_q.push_back(DirTbl[i]);
    while (stim_q.size() < $size(DirTbl) + RandomWords) begin
      case ($urandom_range(0, 9))
        8: push_frame(1'b1);
        9: repeat ($urandom_range(1, 6)) push_raw(pick_byte());
        default: push_frame(1'b0);
      endcase
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    burst = $urandom_range(1, 20);
    while (stim_q.size() > 0) begin
      w = stim_q.pop_front();
      if (burst == 0) begin
        in_valid <= 1'b0;
        rx_byte <= 8'($urandom);
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 20);
      end
      burst--;
      in_valid <= 1'b1;
      rx_byte <= w.b;
      do @(posedge clk); while (!in_ready);
      if (decode_slip_byte(w.b, rep)) frame_reports_q.push_back(w.fixed ? w.rep : rep);
    end
    in_valid <= 1'b0;
    while (frame_reports_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("slip_message_receiver regression: pass");
    else $display("slip_message_receiver regression: fail");
    $finish;
  end

  // receiver: long hold-off early on, then free, random and patterned stretches
  initial begin
    int       cyc;
    int       left;
    rx_mode_e mode;
    cyc = 0;
    left = 0;
    mode = RxFree;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc >= 200 && cyc < 500) begin
        out_ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          RxFree:   out_ready <= 1'b1;
          RxRandom: out_ready <= 1'($urandom_range(0, 1));
          default:  out_ready <= (cyc % 5) < 3;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    report_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (frame_reports_q.size() == 0) begin
        $display("%0t: unexpected word, status %0h cmd %0h len %0h", $time,
                 frame_status, command_code, payload_length);
        errors++;
      end else begin
        exp_r = frame_reports_q.pop_front();
        check_field("frame_status", exp_r.status, frame_status);
        check_field("command_code", exp_r.cmd, command_code);
        check_field("payload_length", exp_r.len, payload_length);
        check_field("ind_value", exp_r.value, ind_value);
        check_field("ind_channel", exp_r.chan, ind_channel);
        check_field("indication_valid", exp_r.ind, indication_valid);
        check_field("overcurrent_alarm", exp_r.oc, overcurrent_alarm);
      end
    end
  end

  initial begin
    #1_000_000;
    $display("slip_message_receiver regression: fail");
    $finish;
  end

endmodule
